// File: rtl/mdps_pkg.sv
package mdps_pkg;

  // widths of the shared divider, sqrt and iteration counter
  localparam int NUM_W = 49;
  localparam int DEN_W = 32;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] DIV_ITERS  = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] SQRT_ITERS = CNT_W'(32);

  // mass = 5 + 155 * m, kept as Q8.16
  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [23:0] MASS_BASE = 24'd327680;
  localparam logic [23:0] MASS_SPAN = 24'd155;
  localparam logic [15:0] NORM_ONE  = 16'd16384;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MASS   = 3'd0,
    CFG_DRAG   = 3'd1,
    CFG_FIX_EN = 3'd2,
    CFG_FIX_X  = 3'd3,
    CFG_FIX_Y  = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_LDX,
    S_DIVX,
    S_LDY,
    S_DIVY,
    S_VEL,
    S_VCHK,
    S_NORM,
    S_SQX,
    S_SQY,
    S_SQSUM,
    S_SQRT,
    S_LDTX,
    S_DIVTX,
    S_LDTY,
    S_DIVTY,
    S_KEEP,
    S_KEEP2,
    S_DAMPX,
    S_DAMPY,
    S_DAMPEND,
    S_MOVE,
    S_DONE
  } fsm_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD_AX,
    OP_LOAD_AY,
    OP_DIV_STEP,
    OP_VEL,
    OP_TILT_ZERO,
    OP_NORM_LOAD,
    OP_NORM_SHIFT,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_SUM,
    OP_SQRT_STEP,
    OP_LOAD_TX,
    OP_LOAD_TY,
    OP_KEEP_MUL,
    OP_KEEP_SET,
    OP_DAMP_X,
    OP_DAMP_Y,
    OP_DAMP_END,
    OP_MOVE,
    OP_OUTPUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_init;
    logic force_zero;
    logic speed_zero;
    logic norm_done;
  } dp_stat_t;

  // saturate a 34 bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (!v[33] && (v[32:31] != 2'b00)) begin
      return 32'sh7fffffff;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // fractions above one count as one
  function automatic logic [16:0] frac_clip(input logic [16:0] f);
    return f[16] ? FRAC_ONE : f;
  endfunction

  // quotient capped at one, then signed
  function automatic logic signed [15:0] unit_part(input logic [NUM_W-1:0] q,
                                                   input logic neg);
    logic [15:0] m;
    m = (q > NUM_W'(NORM_ONE)) ? NORM_ONE : q[15:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// File: rtl/mdps_ctrl.sv
module mdps_ctrl import mdps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  fsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = (stat.is_init || stat.force_zero) ? S_DONE : S_LDX;
      S_LDX:     state_nxt = S_DIVX;
      S_DIVX: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_ITERS - 1'b1) state_nxt = S_LDY;
      end
      S_LDY:     state_nxt = S_DIVY;
      S_DIVY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_ITERS - 1'b1) state_nxt = S_VEL;
      end
      S_VEL:     state_nxt = S_VCHK;
      S_VCHK:    state_nxt = stat.speed_zero ? S_DONE : S_NORM;
      S_NORM:    if (stat.norm_done) state_nxt = S_SQX;
      S_SQX:     state_nxt = S_SQY;
      S_SQY:     state_nxt = S_SQSUM;
      S_SQSUM:   state_nxt = S_SQRT;
      S_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_ITERS - 1'b1) state_nxt = S_LDTX;
      end
      S_LDTX:    state_nxt = S_DIVTX;
      S_DIVTX: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_ITERS - 1'b1) state_nxt = S_LDTY;
      end
      S_LDTY:    state_nxt = S_DIVTY;
      S_DIVTY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_ITERS - 1'b1) state_nxt = S_KEEP;
      end
      S_KEEP:    state_nxt = S_KEEP2;
      S_KEEP2:   state_nxt = S_DAMPX;
      S_DAMPX:   state_nxt = S_DAMPY;
      S_DAMPY:   state_nxt = S_DAMPEND;
      S_DAMPEND: state_nxt = S_MOVE;
      S_MOVE:    state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE:    if (in_valid) cmd.op = OP_ACCEPT;
      S_LDX:     cmd.op = OP_LOAD_AX;
      S_LDY:     cmd.op = OP_LOAD_AY;
      S_DIVX, S_DIVY, S_DIVTX, S_DIVTY: cmd.op = OP_DIV_STEP;
      S_VEL:     cmd.op = OP_VEL;
      S_VCHK:    cmd.op = stat.speed_zero ? OP_TILT_ZERO : OP_NORM_LOAD;
      S_NORM:    if (!stat.norm_done) cmd.op = OP_NORM_SHIFT;
      S_SQX:     cmd.op = OP_SQ_X;
      S_SQY:     cmd.op = OP_SQ_Y;
      S_SQSUM:   cmd.op = OP_SQ_SUM;
      S_SQRT:    cmd.op = OP_SQRT_STEP;
      S_LDTX:    cmd.op = OP_LOAD_TX;
      S_LDTY:    cmd.op = OP_LOAD_TY;
      S_KEEP:    cmd.op = OP_KEEP_MUL;
      S_KEEP2:   cmd.op = OP_KEEP_SET;
      S_DAMPX:   cmd.op = OP_DAMP_X;
      S_DAMPY:   cmd.op = OP_DAMP_Y;
      S_DAMPEND: cmd.op = OP_DAMP_END;
      S_MOVE:    cmd.op = OP_MOVE;
      S_DONE:    if (out_free) cmd.op = OP_OUTPUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // state, counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/mdps_dp.sv
module mdps_dp import mdps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic               in_opcode,
  input  logic signed [31:0] in_cursor_x,
  input  logic signed [31:0] in_cursor_y,
  input  logic [16:0]        mass_fraction,
  input  logic [16:0]        drag_fraction,
  input  logic               fix_en,
  input  logic signed [15:0] fix_x,
  input  logic signed [15:0] fix_y,
  output dp_stat_t           stat,
  output logic               out_moved,
  output logic signed [31:0] out_pen_x,
  output logic signed [31:0] out_pen_y,
  output logic signed [31:0] out_last_x,
  output logic signed [31:0] out_last_y,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y
);

  // filter state
  logic signed [31:0] pos_x_r, pos_y_r, prior_x_r, prior_y_r;
  logic signed [31:0] speed_x_r, speed_y_r;
  logic signed [15:0] tilt_x_r, tilt_y_r;
  logic               moved_r;

  // work registers
  logic               opcode_r;
  logic signed [32:0] fx_r, fy_r;
  logic signed [31:0] ax_r;
  logic [31:0]        ux_r, uy_r;
  logic [63:0]        prod_r, acc_r;
  logic [63:0]        sq_s_r, sq_res_r, sq_bit_r;
  logic [32:0]        keep_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   rem_r, den_r;
  logic signed [15:0] cand_x_r, cand_y_r;

  // output register
  logic               out_moved_r;
  logic signed [31:0] out_pen_x_r, out_pen_y_r, out_last_x_r, out_last_y_r;
  logic signed [15:0] out_normal_x_r, out_normal_y_r;

  logic [32:0]        mag_fx, mag_fy;
  logic [16:0]        mass_clip, drag_clip;
  logic [23:0]        mass16;
  logic [DEN_W:0]     div_t, div_sub;
  logic               div_ge;
  logic [31:0]        qa;
  logic signed [31:0] q_pos, q_neg;
  logic signed [33:0] vx_sum, vy_sum, px_sum, py_sum;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [31:0]        root;
  logic [31:0]        mag_sx, mag_sy, damp_src, damp_mag;
  logic               damp_neg;
  logic [64:0]        damp_rnd;
  logic signed [31:0] damp_val;

  assign mag_fx    = fx_r[32] ? 33'(-fx_r) : 33'(fx_r);
  assign mag_fy    = fy_r[32] ? 33'(-fy_r) : 33'(fy_r);
  assign mass_clip = frac_clip(mass_fraction);
  assign drag_clip = frac_clip(drag_fraction);
  assign mass16    = MASS_BASE + 24'(mass_clip) * MASS_SPAN;

  // one restoring divider step
  assign div_t   = {rem_r, num_r[NUM_W-1]};
  assign div_ge  = div_t >= {1'b0, den_r};
  assign div_sub = div_t - {1'b0, den_r};

  // acceleration quotient with the force sign
  assign qa    = {1'b0, num_r[30:0]};
  assign q_pos = $signed(qa);
  assign q_neg = -$signed(qa);

  assign vx_sum = 34'(speed_x_r) + 34'(ax_r);
  assign vy_sum = 34'(speed_y_r) + 34'(fy_r[32] ? q_neg : q_pos);
  assign px_sum = 34'(pos_x_r) + 34'(speed_x_r);
  assign py_sum = 34'(pos_y_r) + 34'(speed_y_r);

  assign mag_sx = mag32(speed_x_r);
  assign mag_sy = mag32(speed_y_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = ux_r;
    mul_b = ux_r;
    case (cmd.op)
      OP_SQ_Y: begin
        mul_a = uy_r;
        mul_b = uy_r;
      end
      OP_KEEP_MUL: begin
        mul_a = 32'(drag_clip);
        mul_b = 32'(drag_clip);
      end
      OP_DAMP_X: begin
        mul_a = mag_sx;
        mul_b = keep_r[31:0];
      end
      OP_DAMP_Y: begin
        mul_a = mag_sy;
        mul_b = keep_r[31:0];
      end
      default: begin
        mul_a = ux_r;
        mul_b = ux_r;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // square root step
  assign sq_t  = sq_res_r + sq_bit_r;
  assign sq_ge = sq_s_r >= sq_t;
  assign root  = sq_res_r[31:0];

  // damping rounds to nearest; full keep passes the magnitude
  assign damp_src = (cmd.op == OP_DAMP_Y) ? mag_sx : mag_sy;
  assign damp_neg = (cmd.op == OP_DAMP_Y) ? speed_x_r[31] : speed_y_r[31];
  assign damp_rnd = {1'b0, prod_r} + 65'h0_8000_0000;
  assign damp_mag = keep_r[32] ? damp_src : damp_rnd[63:32];
  assign damp_val = damp_neg ? -$signed(damp_mag) : $signed(damp_mag);

  assign stat.is_init    = !opcode_r;
  assign stat.force_zero = (fx_r == '0) && (fy_r == '0);
  assign stat.speed_zero = (speed_x_r == '0) && (speed_y_r == '0);
  assign stat.norm_done  = ux_r[31] | ux_r[30] | uy_r[31] | uy_r[30];

  // filter state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      prior_x_r <= '0;
      prior_y_r <= '0;
      speed_x_r <= '0;
      speed_y_r <= '0;
      tilt_x_r  <= '0;
      tilt_y_r  <= '0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if (!in_opcode) begin
            pos_x_r   <= in_cursor_x;
            pos_y_r   <= in_cursor_y;
            prior_x_r <= in_cursor_x;
            prior_y_r <= in_cursor_y;
            speed_x_r <= '0;
            speed_y_r <= '0;
          end
        end
        OP_VEL: begin
          speed_x_r <= sat32(vx_sum);
          speed_y_r <= sat32(vy_sum);
        end
        OP_TILT_ZERO: begin
          tilt_x_r <= '0;
          tilt_y_r <= '0;
        end
        OP_DAMP_Y:   speed_x_r <= damp_val;
        OP_DAMP_END: speed_y_r <= damp_val;
        OP_MOVE: begin
          prior_x_r <= pos_x_r;
          prior_y_r <= pos_y_r;
          pos_x_r   <= sat32(px_sum);
          pos_y_r   <= sat32(py_sum);
          tilt_x_r  <= fix_en ? fix_x : cand_x_r;
          tilt_y_r  <= fix_en ? fix_y : cand_y_r;
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        opcode_r <= in_opcode;
        fx_r     <= 33'(in_cursor_x) - 33'(pos_x_r);
        fy_r     <= 33'(in_cursor_y) - 33'(pos_y_r);
        moved_r  <= 1'b0;
      end
      OP_LOAD_AX: begin
        num_r <= {mag_fx, 16'b0} + NUM_W'(mass16 >> 1);
        den_r <= DEN_W'(mass16);
        rem_r <= '0;
      end
      OP_LOAD_AY: begin
        ax_r  <= fx_r[32] ? q_neg : q_pos;
        num_r <= {mag_fy, 16'b0} + NUM_W'(mass16 >> 1);
        rem_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? div_sub[DEN_W-1:0] : div_t[DEN_W-1:0];
        num_r <= {num_r[NUM_W-2:0], div_ge};
      end
      OP_NORM_LOAD: begin
        ux_r <= mag_sx;
        uy_r <= mag_sy;
      end
      OP_NORM_SHIFT: begin
        ux_r <= {ux_r[30:0], 1'b0};
        uy_r <= {uy_r[30:0], 1'b0};
      end
      OP_SQ_X: prod_r <= mul_p;
      OP_SQ_Y: begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      OP_SQ_SUM: begin
        sq_s_r   <= acc_r + prod_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_s_r   <= sq_s_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_LOAD_TX: begin
        num_r <= NUM_W'({uy_r, 14'b0}) + NUM_W'(root >> 1);
        den_r <= root;
        rem_r <= '0;
      end
      OP_LOAD_TY: begin
        cand_x_r <= unit_part(num_r, !speed_y_r[31] && (speed_y_r != '0));
        num_r    <= NUM_W'({ux_r, 14'b0}) + NUM_W'(root >> 1);
        rem_r    <= '0;
      end
      OP_KEEP_MUL: begin
        cand_y_r <= unit_part(num_r, speed_x_r[31]);
        prod_r   <= mul_p;
      end
      OP_KEEP_SET: keep_r <= 33'h1_0000_0000 - prod_r[32:0];
      OP_DAMP_X:   prod_r <= mul_p;
      OP_DAMP_Y:   prod_r <= mul_p;
      OP_MOVE:     moved_r <= 1'b1;
      OP_OUTPUT: begin
        out_moved_r    <= moved_r;
        out_pen_x_r    <= pos_x_r;
        out_pen_y_r    <= pos_y_r;
        out_last_x_r   <= prior_x_r;
        out_last_y_r   <= prior_y_r;
        out_normal_x_r <= tilt_x_r;
        out_normal_y_r <= tilt_y_r;
      end
      default: ;
    endcase
  end

  assign out_moved    = out_moved_r;
  assign out_pen_x    = out_pen_x_r;
  assign out_pen_y    = out_pen_y_r;
  assign out_last_x   = out_last_x_r;
  assign out_last_y   = out_last_y_r;
  assign out_normal_x = out_normal_x_r;
  assign out_normal_y = out_normal_y_r;

endmodule

// File: rtl/mass_drag_pen_smoother_top.sv
// pen smoother: mass and drag filter over a stream of 2-D cursor positions
// input channel in_valid/in_stall carries opcode (0 place pen, 1 sample) and
// the cursor; each item gives exactly one result beat on out_valid/out_stall
// holding moved, new pen position, position before the step and the normal
// config port cfg_valid/cfg_ready (always ready) writes register cfg_index:
// 0 mass, 1 drag, 2 fixed angle enable, 3 fixed angle x, 4 fixed angle y
// one item is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register
// a place item or a sample with zero force goes straight from the check to
// the output; a sample with zero velocity stops after the velocity update;
// a full step runs the shared restoring divider four times, plus a square
// root and up to 30 normalizing shifts
// a finished result waits in the output register while out_stall is high;
// the next item can be accepted meanwhile, and its own result waits until
// the register is free
// synchronous active-low reset clears pen state, velocity, normal and
// control, and sets the config registers to their defaults
module mass_drag_pen_smoother_top import mdps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [31:0] in_cursor_x,
  input  logic signed [31:0] in_cursor_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_moved,
  output logic signed [31:0] out_pen_x,
  output logic signed [31:0] out_pen_y,
  output logic signed [31:0] out_last_x,
  output logic signed [31:0] out_last_y,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  logic [16:0]        mass_r, drag_r;
  logic               fix_en_r;
  logic signed [15:0] fix_x_r, fix_y_r;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r   <= 17'd32768;
      drag_r   <= '0;
      fix_en_r <= 1'b0;
      fix_x_r  <= 16'sd16384;
      fix_y_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MASS:   mass_r   <= cfg_data;
        CFG_DRAG:   drag_r   <= cfg_data;
        CFG_FIX_EN: fix_en_r <= cfg_data[0];
        CFG_FIX_X:  fix_x_r  <= cfg_data[15:0];
        CFG_FIX_Y:  fix_y_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mdps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mdps_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_opcode     (in_opcode),
    .in_cursor_x   (in_cursor_x),
    .in_cursor_y   (in_cursor_y),
    .mass_fraction (mass_r),
    .drag_fraction (drag_r),
    .fix_en        (fix_en_r),
    .fix_x         (fix_x_r),
    .fix_y         (fix_y_r),
    .stat          (stat),
    .out_moved     (out_moved),
    .out_pen_x     (out_pen_x),
    .out_pen_y     (out_pen_y),
    .out_last_x    (out_last_x),
    .out_last_y    (out_last_y),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y)
  );

`ifndef ASSERT_OFF
  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  // a result only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without an item in work");
`endif

endmodule

// File: verif/mass_drag_pen_smoother_top_tb.sv
`timescale 1ns / 100ps

module mass_drag_pen_smoother_top_tb;
  import mdps_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic signed [31:0] in_cursor_x;
  logic signed [31:0] in_cursor_y;
  logic               out_valid;
  logic               out_stall;
  logic               out_moved;
  logic signed [31:0] out_pen_x;
  logic signed [31:0] out_pen_y;
  logic signed [31:0] out_last_x;
  logic signed [31:0] out_last_y;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [16:0]        cfg_data;

  localparam logic OPC_PLACE  = 1'b0;
  localparam logic OPC_SAMPLE = 1'b1;

  typedef struct packed {
    logic               moved;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } pen_beat_t;

  pen_beat_t pending_beats[$];
  int        error_count;
  int        hold_cycles;
  int        rx_mode;

  // shadow of the pen and the settings
  logic [16:0]        sh_mass, sh_drag;
  logic               sh_fix_en;
  logic signed [15:0] sh_fix_x, sh_fix_y;
  longint             p_x, p_y, q_x, q_y, v_x, v_y;
  longint             t_x, t_y;

  mass_drag_pen_smoother_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("mass_drag_pen_smoother_top_tb failed");
    $finish;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint unsigned a, longint unsigned r, bit neg);
    longint unsigned qv;
    qv = ((a << 14) + r / 2) / r;
    if (qv > 16384) qv = 16384;
    return neg ? -longint'(qv) : longint'(qv);
  endfunction

  // advance the pen shadow for one beat and queue the expected result
  task automatic predict_pen(logic opc, longint cx, longint cy);
    longint unsigned m, d, mass16, keep, ux, uy, big, r;
    longint fx, fy, ax, ay;
    pen_beat_t e;
    e.moved = 1'b0;
    if (opc == OPC_PLACE) begin
      p_x = cx; q_x = cx; p_y = cy; q_y = cy; v_x = 0; v_y = 0;
    end else begin
      m = sh_mass[16] ? 65536 : sh_mass;
      d = sh_drag[16] ? 65536 : sh_drag;
      mass16 = 5 * 65536 + 155 * m;
      keep = (64'd1 << 32) - d * d;
      fx = cx - p_x;
      fy = cy - p_y;
      if (fx != 0 || fy != 0) begin
        ax = ((absval(fx) << 16) + mass16 / 2) / mass16;
        ay = ((absval(fy) << 16) + mass16 / 2) / mass16;
        if (fx < 0) ax = -ax;
        if (fy < 0) ay = -ay;
        v_x = clip32(v_x + ax);
        v_y = clip32(v_y + ay);
        if (v_x == 0 && v_y == 0) begin
          t_x = 0; t_y = 0;
        end else begin
          ux = absval(v_x);
          uy = absval(v_y);
          big = ux > uy ? ux : uy;
          while (big < (64'd1 << 30)) begin
            ux <<= 1; uy <<= 1; big <<= 1;
          end
          r = root_floor(ux * ux + uy * uy);
          t_x = unit_comp(uy, r, v_y > 0);
          t_y = unit_comp(ux, r, v_x < 0);
          if (sh_fix_en) begin
            t_x = longint'(sh_fix_x);
            t_y = longint'(sh_fix_y);
          end
          ux = (absval(v_x) * keep + (64'd1 << 31)) >> 32;
          uy = (absval(v_y) * keep + (64'd1 << 31)) >> 32;
          v_x = v_x < 0 ? -longint'(ux) : longint'(ux);
          v_y = v_y < 0 ? -longint'(uy) : longint'(uy);
          q_x = p_x; q_y = p_y;
          p_x = clip32(p_x + v_x);
          p_y = clip32(p_y + v_y);
          e.moved = 1'b1;
        end
      end
    end
    e.pen_x = p_x[31:0];
    e.pen_y = p_y[31:0];
    e.last_x = q_x[31:0];
    e.last_y = q_y[31:0];
    e.normal_x = t_x[15:0];
    e.normal_y = t_y[15:0];
    pending_beats.push_back(e);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    pen_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        e = pending_beats.pop_front();
        if (out_moved !== e.moved) report_mismatch("moved", out_moved, e.moved);
        if (out_pen_x !== e.pen_x) report_mismatch("pen_x", out_pen_x, e.pen_x);
        if (out_pen_y !== e.pen_y) report_mismatch("pen_y", out_pen_y, e.pen_y);
        if (out_last_x !== e.last_x) report_mismatch("last_x", out_last_x, e.last_x);
        if (out_last_y !== e.last_y) report_mismatch("last_y", out_last_y, e.last_y);
        if (out_normal_x !== e.normal_x)
          report_mismatch("normal_x", out_normal_x, e.normal_x);
        if (out_normal_y !== e.normal_y)
          report_mismatch("normal_y", out_normal_y, e.normal_y);
      end
    end
  end

  // receiver stalls: random gaps, or a forced long hold
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (rx_mode == 0) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_cycles <= $urandom_range(50, 400);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic opc, logic signed [31:0] cx, logic signed [31:0] cy,
                           int gaps);
    int gap;
    gap = 0;
    if (gaps != 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    end
    repeat (gap + 1) @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= opc;
    in_cursor_x <= cx;
    in_cursor_y <= cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pen(opc, cx, cy);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (pending_beats.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MASS:   sh_mass = val;
      CFG_DRAG:   sh_drag = val;
      CFG_FIX_EN: sh_fix_en = val[0];
      CFG_FIX_X:  sh_fix_x = val[15:0];
      CFG_FIX_Y:  sh_fix_y = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] near_cursor(longint base, int span);
    longint v;
    v = base + $signed($urandom_range(0, 2 * span)) - span;
    return 32'(clip32(v));
  endfunction

  task automatic test_directed();
    send_item(OPC_SAMPLE, 0, 0, 0);
    send_item(OPC_SAMPLE, 32'sd4096, -32'sd4096, 0);
    send_item(OPC_SAMPLE, 32'sd4096, -32'sd4096, 0);
    send_item(OPC_PLACE, 32'sh7fffffff, 32'sh80000000, 0);
    send_item(OPC_SAMPLE, 32'sh80000000, 32'sh7fffffff, 0);
    send_item(OPC_SAMPLE, 32'sh80000000, 32'sh7fffffff, 0);
    send_item(OPC_PLACE, 0, 0, 0);
    send_item(OPC_SAMPLE, 1, 0, 0);
    send_item(OPC_SAMPLE, 0, -1, 0);
    send_item(OPC_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_item(OPC_SAMPLE, 32'sh7fffffff, 32'sh7fffffff, 0);
    // a pull back past the start reverses the velocity
    send_item(OPC_PLACE, 0, 0, 0);
    send_item(OPC_SAMPLE, 32'sd1000000, 0, 0);
    send_item(OPC_SAMPLE, -32'sd999000, 0, 0);
    send_item(OPC_SAMPLE, 32'sd5000, 32'sd9000, 0);
    drain_results();
  endtask

  task automatic test_settings(logic [16:0] m, logic [16:0] d, bit en,
                               logic signed [15:0] fx, logic signed [15:0] fy);
    write_reg(CFG_MASS, m);
    write_reg(CFG_DRAG, d);
    write_reg(CFG_FIX_EN, 17'(en));
    write_reg(CFG_FIX_X, 17'(fx));
    write_reg(CFG_FIX_Y, 17'(fy));
  endtask

  // mostly strokes near the pen, some full-range noise, places and samples on the pen
  task automatic test_random_strokes(int n);
    int kind;
    logic signed [31:0] cx, cy;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        send_item(OPC_PLACE, $urandom, $urandom, 1);
      end else if (kind < 10) begin
        send_item(OPC_SAMPLE, $urandom, $urandom, 1);
      end else if (kind < 14) begin
        send_item(OPC_SAMPLE, p_x[31:0], p_y[31:0], 1);
      end else begin
        cx = near_cursor(p_x, (kind < 60) ? 2000 : 2000000);
        cy = near_cursor(p_y, (kind < 60) ? 2000 : 2000000);
        send_item(OPC_SAMPLE, cx, cy, 1);
      end
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_cycles = 2000;
    for (int i = 0; i < 6; i++)
      send_item(OPC_SAMPLE, near_cursor(p_x, 50000), near_cursor(p_y, 50000), 0);
    drain_results();
    // sender waits for everything before the next item
    for (int i = 0; i < 4; i++) begin
      send_item(OPC_SAMPLE, near_cursor(p_x, 9000), near_cursor(p_y, 9000), 0);
      drain_results();
    end
  endtask

  initial begin
    error_count = 0;
    hold_cycles = 0;
    rx_mode = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OPC_PLACE;
    in_cursor_x = '0;
    in_cursor_y = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MASS;
    cfg_data = '0;
    sh_mass = 17'd32768;
    sh_drag = '0;
    sh_fix_en = 1'b0;
    sh_fix_x = 16'sd16384;
    sh_fix_y = '0;
    p_x = 0; p_y = 0; q_x = 0; q_y = 0; v_x = 0; v_y = 0; t_x = 0; t_y = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    rx_mode = 1;
    test_random_strokes(200);
    test_settings(17'd0, 17'd0, 1'b0, 16'sd16384, 16'sd0);
    test_random_strokes(200);
    test_settings(17'h1ffff, 17'h1ffff, 1'b0, -16'sd16384, 16'sd16384);
    test_random_strokes(150);
    test_settings(17'd65536, 17'd65535, 1'b1, -16'sd16384, -16'sd16384);
    test_random_strokes(150);
    test_settings(17'd12000, 17'd30000, 1'b1, 16'sh7fff, 16'sh8000);
    test_backpressure();
    test_random_strokes(150);
    test_settings(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)), 1'b0,
                  16'($urandom), 16'($urandom));
    test_random_strokes(200);
    test_settings(17'd40000, 17'd20000, 1'b1, 16'sd11585, -16'sd11585);
    test_random_strokes(100);

    if (pending_beats.size() != 0)
      report_mismatch("missing beats", pending_beats.size(), 0);
    if (error_count == 0) begin
      $display("mass_drag_pen_smoother_top_tb passed");
    end else begin
      $display("mass_drag_pen_smoother_top_tb failed");
    end
    $finish;
  end

endmodule
